// ===== rtl/core/brb_pkg.sv =====
// Shared types and constants for the byte ring buffer pool.
// Used by every module of the block but brb_ram; depends on nothing.
package brb_pkg;

  // Default geometry of the pool
  localparam int BUFFER_BYTES_DEF = 4096;
  localparam int BUFFER_COUNT_DEF = 8;

  // Depth of the command and result queues
  localparam int QUEUE_DEPTH = 2;

  // Fixed field widths
  localparam int CMD_W  = 3;
  localparam int ID_W   = 3;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 13;

  // Command codes on the input port
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_WRITE   = 3'd2,
    CMD_READ    = 3'd3,
    CMD_DISCARD = 3'd4
  } cmd_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_WRITE,
    OP_READ,
    OP_DISCARD,
    OP_STATUS,  // unknown command on a valid buffer: report only
    OP_NULL     // buffer id out of range: all-zero result
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [ID_W-1:0]     id;
    logic [BYTE_W-1:0]   data;
    logic [LEN_W-1:0]    len;
  } op_t;

  typedef struct packed {
    logic                ok;
    logic [ID_W-1:0]     granted_id;
    logic [BYTE_W-1:0]   read_byte;
    logic [LEN_W-1:0]    dropped_count;
    logic [LEN_W-1:0]    used_bytes;
    logic [LEN_W-1:0]    space_bytes;
  } res_t;

endpackage

// ===== rtl/core/brb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/brb_fifo.sv =====
// Small flop-based queue used between front and back and on the result side.
// Depends on brb_pkg for the default depth.
module brb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = brb_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/brb_front.sv =====
// Front end: accepts commands, classifies them and queues them for the back end.
// Depends on brb_pkg and brb_fifo.
module brb_front #(
  parameter int BUFFER_COUNT = brb_pkg::BUFFER_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [brb_pkg::CMD_W-1:0]   command,
  input  logic [brb_pkg::ID_W-1:0]    buffer_id,
  input  logic [brb_pkg::BYTE_W-1:0]  data_byte,
  input  logic [brb_pkg::LEN_W-1:0]   discard_length,
  output logic                        op_valid,
  output brb_pkg::op_t                op,
  input  logic                        op_take
);

  brb_pkg::op_t op_in;
  logic         in_range;
  logic         op_empty;

  assign in_range = (32'(buffer_id) < 32'(BUFFER_COUNT));

  // Classify the command
  always_comb begin
    op_in.id   = buffer_id;
    op_in.data = data_byte;
    op_in.len  = discard_length;
    priority if (command == brb_pkg::CMD_ALLOC) begin
      op_in.kind = brb_pkg::OP_ALLOC;
    end else if (!in_range) begin
      op_in.kind = brb_pkg::OP_NULL;
    end else begin
      unique case (command)
        brb_pkg::CMD_FREE:    op_in.kind = brb_pkg::OP_FREE;
        brb_pkg::CMD_WRITE:   op_in.kind = brb_pkg::OP_WRITE;
        brb_pkg::CMD_READ:    op_in.kind = brb_pkg::OP_READ;
        brb_pkg::CMD_DISCARD: op_in.kind = brb_pkg::OP_DISCARD;
        default:              op_in.kind = brb_pkg::OP_STATUS;
      endcase
    end
  end

  // Command queue toward the back end
  brb_fifo #(
    .WIDTH ($bits(brb_pkg::op_t)),
    .DEPTH (brb_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (op_in),
    .full  (full),
    .pop   (op_take),
    .rdata (op),
    .empty (op_empty)
  );

  assign op_valid = !op_empty;

endmodule

// ===== rtl/core/brb_back.sv =====
// Back end: per-buffer pointers, allocation, byte store and result queue.
// Depends on brb_pkg, brb_ram and brb_fifo.
module brb_back #(
  parameter int BUFFER_BYTES = brb_pkg::BUFFER_BYTES_DEF,
  parameter int BUFFER_COUNT = brb_pkg::BUFFER_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  input  brb_pkg::op_t  op,
  output logic          op_take,
  output logic          res_empty,
  input  logic          res_pop,
  output brb_pkg::res_t res
);

  localparam int PW  = $clog2(BUFFER_BYTES);
  localparam int FW  = $clog2(BUFFER_BYTES + 1);
  localparam int IW  = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int DEPTH = BUFFER_COUNT * BUFFER_BYTES;
  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = (FW > brb_pkg::LEN_W) ? FW : brb_pkg::LEN_W;
  localparam logic [AW-1:0] BB_A = AW'(BUFFER_BYTES);
  localparam logic [FW-1:0] BB_F = FW'(BUFFER_BYTES);

  // Per-buffer state
  logic [PW-1:0] write_position [BUFFER_COUNT];
  logic [PW-1:0] read_position  [BUFFER_COUNT];
  logic [FW-1:0] fill_count     [BUFFER_COUNT];
  logic          claimed        [BUFFER_COUNT];

  // Execute-stage signals
  logic          fire;
  logic          any_free;
  logic [IW-1:0] grant;
  logic [IW-1:0] tgt;
  logic [PW-1:0] cur_wp, cur_rp, new_wp, new_rp;
  logic [FW-1:0] cur_fill, new_fill, drop;
  logic [CW-1:0] drop_w;
  logic          new_claim;
  logic          upd;
  logic          report;
  logic          mem_we, mem_re;
  logic [AW-1:0] base;
  brb_pkg::res_t exe_res;

  // Result stage
  logic          r_valid;
  logic          r_rd;
  brb_pkg::res_t r_res;
  brb_pkg::res_t r_out;
  logic [brb_pkg::BYTE_W-1:0] ram_rdata;
  logic          res_full;

  // Ring pointer advance; sum stays below twice the buffer size
  function automatic logic [PW-1:0] advance(input logic [PW-1:0] pos,
                                            input logic [FW-1:0] n);
    logic [FW:0] sum;
    sum = (FW+1)'(pos) + (FW+1)'(n);
    if (sum >= (FW+1)'(BUFFER_BYTES)) begin
      sum = sum - (FW+1)'(BUFFER_BYTES);
    end
    return PW'(sum);
  endfunction

  // Lowest-numbered free buffer
  always_comb begin
    any_free = 1'b0;
    grant    = '0;
    for (int i = BUFFER_COUNT - 1; i >= 0; i--) begin
      if (!claimed[i]) begin
        any_free = 1'b1;
        grant    = IW'(i);
      end
    end
  end

  assign fire    = op_valid && (!r_valid || !res_full);
  assign op_take = fire;

  assign tgt      = (op.kind == brb_pkg::OP_ALLOC) ? grant : IW'(op.id);
  assign cur_wp   = write_position[tgt];
  assign cur_rp   = read_position[tgt];
  assign cur_fill = fill_count[tgt];
  assign base     = AW'(tgt) * BB_A;
  assign drop_w   = (CW'(op.len) < CW'(cur_fill)) ? CW'(op.len) : CW'(cur_fill);
  assign drop     = FW'(drop_w);

  // Operation decode and next state of the addressed buffer
  always_comb begin
    new_wp    = cur_wp;
    new_rp    = cur_rp;
    new_fill  = cur_fill;
    new_claim = claimed[tgt];
    upd       = 1'b0;
    report    = 1'b1;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    exe_res   = '0;
    unique case (op.kind)
      brb_pkg::OP_ALLOC: begin
        if (any_free) begin
          upd                = 1'b1;
          new_wp             = '0;
          new_rp             = '0;
          new_fill           = '0;
          new_claim          = 1'b1;
          exe_res.ok         = 1'b1;
          exe_res.granted_id = brb_pkg::ID_W'(grant);
        end else begin
          report = 1'b0;
        end
      end
      brb_pkg::OP_FREE: begin
        upd       = 1'b1;
        new_wp    = '0;
        new_rp    = '0;
        new_fill  = '0;
        new_claim = 1'b0;
      end
      brb_pkg::OP_WRITE: begin
        if (cur_fill < BB_F) begin
          upd        = 1'b1;
          mem_we     = 1'b1;
          new_wp     = advance(cur_wp, FW'(1));
          new_fill   = cur_fill + FW'(1);
          exe_res.ok = 1'b1;
        end
      end
      brb_pkg::OP_READ: begin
        if (cur_fill != '0) begin
          upd        = 1'b1;
          mem_re     = 1'b1;
          new_rp     = advance(cur_rp, FW'(1));
          new_fill   = cur_fill - FW'(1);
          exe_res.ok = 1'b1;
        end
      end
      brb_pkg::OP_DISCARD: begin
        upd                   = 1'b1;
        new_rp                = advance(cur_rp, drop);
        new_fill              = cur_fill - drop;
        exe_res.dropped_count = brb_pkg::LEN_W'(drop);
      end
      brb_pkg::OP_STATUS: begin
        upd = 1'b0;
      end
      brb_pkg::OP_NULL: begin
        report = 1'b0;
      end
      default: begin
        report = 1'b0;
      end
    endcase
    if (report) begin
      exe_res.used_bytes  = brb_pkg::LEN_W'(new_fill);
      exe_res.space_bytes = brb_pkg::LEN_W'(BB_F - new_fill);
    end
  end

  // Per-buffer state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUFFER_COUNT; i++) begin
        write_position[i] <= '0;
        read_position[i]  <= '0;
        fill_count[i]     <= '0;
        claimed[i]        <= 1'b0;
      end
    end else if (fire && upd) begin
      write_position[tgt] <= new_wp;
      read_position[tgt]  <= new_rp;
      fill_count[tgt]     <= new_fill;
      claimed[tgt]        <= new_claim;
    end
  end

  // Shared byte store
  brb_ram #(
    .WIDTH (brb_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (fire && mem_we),
    .waddr (base + AW'(cur_wp)),
    .wdata (op.data),
    .re    (fire && mem_re),
    .raddr (base + AW'(cur_rp)),
    .rdata (ram_rdata)
  );

  // Result stage: holds the registered result alongside the store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (fire) begin
      r_valid <= 1'b1;
    end else if (r_valid && !res_full) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      r_res <= exe_res;
      r_rd  <= mem_re;
    end
  end

  always_comb begin
    r_out = r_res;
    if (r_rd) begin
      r_out.read_byte = ram_rdata;
    end
  end

  // Result queue
  brb_fifo #(
    .WIDTH ($bits(brb_pkg::res_t)),
    .DEPTH (brb_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_valid),
    .wdata (r_out),
    .full  (res_full),
    .pop   (res_pop),
    .rdata (res),
    .empty (res_empty)
  );

endmodule

// ===== rtl/core/byte_ring_buffer_pool.sv =====
// Top level of the byte ring buffer pool: front end, back end and result ports.
// Depends on brb_pkg, brb_front and brb_back.
//
//   channel   direction  handshake            payload
//   command   in         push / full          command, buffer_id, data_byte,
//                                             discard_length
//   result    out        pop / empty          ok, granted_id, read_byte,
//                                             dropped_count, used_bytes, space_bytes
//
// One command per cycle sustained while the result queue has room; the back end
// executes one command a cycle against the per-buffer pointer registers, so state is
// current for the next one. A command goes from the command queue to execute, then
// the store read stage feeds the result queue. Synchronous reset empties both queues
// and frees all buffers at once; store contents are not cleared. A stalled result
// queue backs up through the execute stage into the command queue, then raises full.
module byte_ring_buffer_pool #(
  parameter int BUFFER_BYTES = brb_pkg::BUFFER_BYTES_DEF,
  parameter int BUFFER_COUNT = brb_pkg::BUFFER_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [brb_pkg::CMD_W-1:0]   command,
  input  logic [brb_pkg::ID_W-1:0]    buffer_id,
  input  logic [brb_pkg::BYTE_W-1:0]  data_byte,
  input  logic [brb_pkg::LEN_W-1:0]   discard_length,
  output logic                        empty,
  input  logic                        pop,
  output logic                        ok,
  output logic [brb_pkg::ID_W-1:0]    granted_id,
  output logic [brb_pkg::BYTE_W-1:0]  read_byte,
  output logic [brb_pkg::LEN_W-1:0]   dropped_count,
  output logic [brb_pkg::LEN_W-1:0]   used_bytes,
  output logic [brb_pkg::LEN_W-1:0]   space_bytes
);

  logic          op_valid;
  logic          op_take;
  brb_pkg::op_t  op;
  brb_pkg::res_t res;

  // Accept and classify
  brb_front #(
    .BUFFER_COUNT (BUFFER_COUNT)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .command        (command),
    .buffer_id      (buffer_id),
    .data_byte      (data_byte),
    .discard_length (discard_length),
    .op_valid       (op_valid),
    .op             (op),
    .op_take        (op_take)
  );

  // Execute and queue results
  brb_back #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .BUFFER_COUNT (BUFFER_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op        (op),
    .op_take   (op_take),
    .res_empty (empty),
    .res_pop   (pop),
    .res       (res)
  );

  assign ok            = res.ok;
  assign granted_id    = res.granted_id;
  assign read_byte     = res.read_byte;
  assign dropped_count = res.dropped_count;
  assign used_bytes    = res.used_bytes;
  assign space_bytes   = res.space_bytes;

endmodule

// ===== rtl/core/brb_checker.sv =====
// Port-level checks for the byte ring buffer pool, bound to the top level.
// Depends on brb_pkg for field widths.
module brb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        push,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic                        ok,
  input logic [brb_pkg::ID_W-1:0]    granted_id,
  input logic [brb_pkg::BYTE_W-1:0]  read_byte,
  input logic [brb_pkg::LEN_W-1:0]   dropped_count,
  input logic [brb_pkg::LEN_W-1:0]   used_bytes
);

  // Commands accepted but not yet delivered
  logic [3:0] outstanding;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 4'(in_xfer) - 4'(out_xfer);
    end
  end

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // No result without an earlier command, and no more in flight than the pipeline holds
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    (!empty |-> outstanding != 4'd0) and (outstanding <= 4'd5))
    else $error("result count does not match accepted commands");

  // A nonzero granted id or read byte only comes with success
  a_ok_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && (granted_id != '0 || read_byte != '0)) |-> ok)
    else $error("granted id or read byte without ok");

  // Discard never reports ok
  a_discard_not_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && dropped_count != '0) |-> !ok)
    else $error("discard result with ok set");

  // A waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(used_bytes) && $stable(read_byte)))
    else $error("waiting result changed");

endmodule

bind byte_ring_buffer_pool brb_checker u_brb_checker (
  .clk           (clk),
  .rst           (rst),
  .push          (push),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .ok            (ok),
  .granted_id    (granted_id),
  .read_byte     (read_byte),
  .dropped_count (dropped_count),
  .used_bytes    (used_bytes)
);
